/* rtl/wss_pkg.sv */
`timescale 1ns / 1ps

package wss_pkg;

    // Default size of the step ring
    localparam int NUM_STEPS_DEF = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_KNOB  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_KNOB = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_KNOB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTINUOUS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTING     = 3'd4;

    // Register reset values
    localparam logic [2:0]  START_KNOB_RST  = 3'd0;
    localparam logic [2:0]  LENGTH_KNOB_RST = 3'd7;
    localparam logic [1:0]  MODE_KNOB_RST   = 2'd0;
    localparam logic        CONTINUOUS_RST  = 1'b0;
    localparam logic [15:0] ROUTING_RST     = 16'd35096;

    // Play modes
    localparam logic [1:0] MODE_FORWARD  = 2'd0;
    localparam logic [1:0] MODE_BACKWARD = 2'd1;
    localparam logic [1:0] MODE_PENDULUM = 2'd2;
    localparam logic [1:0] MODE_RANDOM   = 2'd3;

    // Trigger routing codes, two bits per step
    localparam logic [1:0] ROUTE_ONE = 2'd1;
    localparam logic [1:0] ROUTE_TWO = 2'd2;

    // Steps covered by the routing register
    localparam int ROUTE_STEPS = 8;

    // Address level of 1.0 over 256
    localparam logic [8:0] ADDR_FULL = 9'd256;

endpackage

/* rtl/windowed_step_sequencer.sv */
`timescale 1ns / 1ps

// Windowed step sequencer: an N-step sequential switch driven once per tick.
// Input channel (in_valid / in_stall) carries one tick word: clock and reset
// edges, patch flags, address level, CV offsets and a random fraction.
// Output channel (out_valid / out_stall) returns one word per tick: the
// selected step, the CV sample strobe and the two trigger fire flags.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), written
// while no tick is in flight.
// All window sums and reductions run through one shared add / conditional-subtract
// unit under a small sequencer; each modulo is a run of subtract passes.
// The time to a result is set by the path taken (hold or reset, address or
// random pick, clocked move) and by the number of subtract passes. A new tick
// is taken only once the previous result has been written out.
// in_stall is high from acceptance until the result is written out.
// A result waits in the output register while out_stall is high; the next
// tick may be accepted meanwhile but finishes only once that word is taken.
// Reset (rst_n low) clears the step to 0, the pendulum direction to forward,
// loads the register defaults and leaves the output channel empty.
module windowed_step_sequencer
    import wss_pkg::*;
#(
    parameter int NUM_STEPS = NUM_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  clock_edge,
    input  logic                  reset_edge,
    input  logic                  clock_connected,
    input  logic                  address_connected,
    input  logic [8:0]            address_level,
    input  logic [3:0]            start_cv,
    input  logic [3:0]            length_cv,
    input  logic [1:0]            mode_cv,
    input  logic [7:0]            random_fraction,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            current_step,
    output logic                  cv_update,
    output logic                  fire_trigger_one,
    output logic                  fire_trigger_two
);

    // Widths: step index, window length, accumulator (holds knob + cv
    // and any sum below twice the ring size)
    localparam int SW      = (NUM_STEPS > 2) ? $clog2(NUM_STEPS) : 1;
    localparam int LW      = $clog2(NUM_STEPS + 1);
    localparam int ACC_MAX = (2 * NUM_STEPS > 23) ? 2 * NUM_STEPS + 1 : 23;
    localparam int AW      = $clog2(ACC_MAX);
    localparam int PW      = 9 + LW;

    localparam logic [AW-1:0] ACC_ONE   = AW'(1);
    localparam logic [AW-1:0] ACC_STEPS = AW'(NUM_STEPS);
    localparam logic [AW-1:0] ACC_ROUTE = AW'(ROUTE_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED,
        S_START_DONE,
        S_LEN_DONE,
        S_MUL,
        S_OFS,
        S_SET,
        S_REL_A,
        S_REL_B,
        S_REL_DONE,
        S_MOVE,
        S_MOVED,
        S_PEND,
        S_FIN
    } state_t;

    // Configuration registers
    logic [2:0]  start_knob_reg;
    logic [2:0]  length_knob_reg;
    logic [1:0]  mode_knob_reg;
    logic        continuous_reg;
    logic [15:0] routing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_knob_reg  <= START_KNOB_RST;
            length_knob_reg <= LENGTH_KNOB_RST;
            mode_knob_reg   <= MODE_KNOB_RST;
            continuous_reg  <= CONTINUOUS_RST;
            routing_reg     <= ROUTING_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_KNOB:  start_knob_reg  <= cfg_data[2:0];
                CFG_LENGTH_KNOB: length_knob_reg <= cfg_data[2:0];
                CFG_MODE_KNOB:   mode_knob_reg   <= cfg_data[1:0];
                CFG_CONTINUOUS:  continuous_reg  <= cfg_data[0];
                CFG_ROUTING:     routing_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Sequencer and datapath registers
    state_t          state_reg,      state_next;
    state_t          ret_reg,        ret_next;
    logic [AW-1:0]   acc_reg,        acc_next;
    logic [AW-1:0]   mod_reg,        mod_next;
    logic [SW-1:0]   start_reg,      start_next;
    logic [SW-1:0]   lm1_reg,        lm1_next;
    logic [LW-1:0]   len_reg,        len_next;
    logic [LW:0]     off_reg,        off_next;
    logic [SW-1:0]   new_step_reg,   new_step_next;
    logic [SW-1:0]   step_pos_reg,   step_pos_next;
    logic            going_back_reg, going_back_next;

    // Captured tick word
    logic            clk_e_reg,      clk_e_next;
    logic            rst_e_reg,      rst_e_next;
    logic            clk_con_reg,    clk_con_next;
    logic            addr_con_reg,   addr_con_next;
    logic [8:0]      addr_reg,       addr_next;
    logic [3:0]      lcv_reg,        lcv_next;
    logic [1:0]      mode_reg,       mode_next;
    logic [7:0]      rnd_reg,        rnd_next;

    // Output word
    logic            out_valid_reg,  out_valid_next;
    logic [2:0]      step_out_reg,   step_out_next;
    logic            cv_upd_reg,     cv_upd_next;
    logic            fire_one_reg,   fire_one_next;
    logic            fire_two_reg,   fire_two_next;

    // Shared add / subtract unit
    logic [AW-1:0]   alu_a;
    logic [AW-1:0]   alu_b;
    logic            alu_sub;
    logic [AW:0]     alu_sum;
    logic [AW-1:0]   alu_y;
    logic            alu_ge;

    logic            in_fire;
    logic            fwd;
    logic [8:0]      factor;
    logic [PW-1:0]   prod;
    logic [AW-1:0]   nstep_ext;
    logic            changed;
    logic [1:0]      route;

    assign in_fire = in_valid && (state_reg == S_IDLE);
    assign fwd     = (mode_reg == MODE_FORWARD) ||
                     ((mode_reg == MODE_PENDULUM) && !going_back_reg);

    // Operand select for the shared unit
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = mod_reg;
        alu_sub = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                alu_a   = {{(AW-3){1'b0}}, start_knob_reg};
                alu_b   = {{(AW-4){1'b0}}, start_cv};
                alu_sub = 1'b0;
            end
            S_START_DONE:
            begin
                alu_a   = {{(AW-3){1'b0}}, length_knob_reg};
                alu_b   = {{(AW-4){1'b0}}, lcv_reg};
                alu_sub = 1'b0;
            end
            S_OFS:
            begin
                alu_a   = {{(AW-SW){1'b0}}, start_reg};
                alu_b   = {{(AW-LW-1){1'b0}}, off_reg};
                alu_sub = 1'b0;
            end
            S_REL_A:
            begin
                alu_a   = {{(AW-SW){1'b0}}, step_pos_reg};
                alu_b   = ACC_STEPS;
                alu_sub = 1'b0;
            end
            S_REL_B:
            begin
                alu_a   = acc_reg;
                alu_b   = {{(AW-SW){1'b0}}, start_reg};
                alu_sub = 1'b1;
            end
            S_REL_DONE:
            begin
                alu_a   = acc_reg;
                alu_b   = fwd ? ACC_ONE : {{(AW-SW){1'b0}}, lm1_reg};
                alu_sub = 1'b0;
            end
            S_MOVE:
            begin
                alu_a   = acc_reg;
                alu_b   = {{(AW-SW){1'b0}}, start_reg};
                alu_sub = 1'b0;
            end
            S_MOVED:
            begin
                alu_a   = {{(AW-SW){1'b0}}, start_reg};
                alu_b   = {{(AW-SW){1'b0}}, lm1_reg};
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a   = acc_reg;
                alu_b   = mod_reg;
                alu_sub = 1'b1;
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + {{AW{1'b0}}, alu_sub};
    assign alu_y   = alu_sum[AW-1:0];
    assign alu_ge  = alu_sum[AW];

    // Offset multiply: address or random fraction times window length
    assign factor = addr_con_reg ? addr_reg : {1'b0, rnd_reg};
    assign prod   = {{LW{1'b0}}, factor} * {{9{1'b0}}, len_reg};

    // Result word fields
    assign nstep_ext = {{(AW-SW){1'b0}}, new_step_reg};
    assign changed   = (clk_con_reg && clk_e_reg) || (new_step_reg != step_pos_reg);
    assign route     = (changed && (nstep_ext < ACC_ROUTE))
                       ? routing_reg[{nstep_ext[2:0], 1'b0} +: 2] : 2'd0;

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        acc_next        = acc_reg;
        mod_next        = mod_reg;
        start_next      = start_reg;
        lm1_next        = lm1_reg;
        len_next        = len_reg;
        off_next        = off_reg;
        new_step_next   = new_step_reg;
        step_pos_next   = step_pos_reg;
        going_back_next = going_back_reg;
        clk_e_next      = clk_e_reg;
        rst_e_next      = rst_e_reg;
        clk_con_next    = clk_con_reg;
        addr_con_next   = addr_con_reg;
        addr_next       = addr_reg;
        lcv_next        = lcv_reg;
        mode_next       = mode_reg;
        rnd_next        = rnd_reg;
        out_valid_next  = out_valid_reg && out_stall;
        step_out_next   = step_out_reg;
        cv_upd_next     = cv_upd_reg;
        fire_one_next   = fire_one_reg;
        fire_two_next   = fire_two_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    clk_e_next    = clock_edge;
                    rst_e_next    = reset_edge;
                    clk_con_next  = clock_connected;
                    addr_con_next = address_connected;
                    addr_next     = (address_level > ADDR_FULL) ? ADDR_FULL
                                                                : address_level;
                    lcv_next      = length_cv;
                    mode_next     = mode_knob_reg + mode_cv;
                    rnd_next      = random_fraction;
                    acc_next      = alu_y;
                    mod_next      = ACC_STEPS;
                    ret_next      = S_START_DONE;
                    state_next    = S_RED;
                end
            end
            // conditional subtract until below the modulus
            S_RED:
            begin
                if (alu_ge)
                    acc_next = alu_y;
                else
                    state_next = ret_reg;
            end
            S_START_DONE:
            begin
                start_next = acc_reg[SW-1:0];
                acc_next   = alu_y;
                mod_next   = ACC_STEPS;
                ret_next   = S_LEN_DONE;
                state_next = S_RED;
            end
            // window known: pick the path for this tick
            S_LEN_DONE:
            begin
                lm1_next = acc_reg[SW-1:0];
                len_next = acc_reg[LW-1:0] + LW'(1);
                if (mode_reg != MODE_PENDULUM)
                    going_back_next = 1'b0;
                new_step_next = step_pos_reg;
                state_next    = S_FIN;
                if (rst_e_reg)
                    new_step_next = start_reg;
                else if (addr_con_reg)
                begin
                    if (!clk_con_reg || clk_e_reg)
                        state_next = S_MUL;
                end
                else if (clk_e_reg)
                begin
                    if (mode_reg == MODE_RANDOM)
                        state_next = S_MUL;
                    else
                        state_next = S_REL_A;
                end
            end
            S_MUL:
            begin
                off_next   = prod[PW-1:8];
                state_next = S_OFS;
            end
            S_OFS:
            begin
                acc_next   = alu_y;
                mod_next   = ACC_STEPS;
                ret_next   = S_SET;
                state_next = S_RED;
            end
            S_SET:
            begin
                new_step_next = acc_reg[SW-1:0];
                state_next    = S_FIN;
            end
            // distance from start, modulo the ring
            S_REL_A:
            begin
                acc_next   = alu_y;
                state_next = S_REL_B;
            end
            S_REL_B:
            begin
                acc_next   = alu_y;
                mod_next   = ACC_STEPS;
                ret_next   = S_REL_DONE;
                state_next = S_RED;
            end
            // move one step inside the window
            S_REL_DONE:
            begin
                acc_next   = alu_y;
                mod_next   = {{(AW-LW){1'b0}}, len_reg};
                ret_next   = S_MOVE;
                state_next = S_RED;
            end
            S_MOVE:
            begin
                acc_next   = alu_y;
                mod_next   = ACC_STEPS;
                ret_next   = S_MOVED;
                state_next = S_RED;
            end
            S_MOVED:
            begin
                new_step_next = acc_reg[SW-1:0];
                if (mode_reg == MODE_PENDULUM)
                begin
                    acc_next   = alu_y;
                    mod_next   = ACC_STEPS;
                    ret_next   = S_PEND;
                    state_next = S_RED;
                end
                else
                    state_next = S_FIN;
            end
            // pendulum turn at either end of the window
            S_PEND:
            begin
                if (new_step_reg == start_reg)
                    going_back_next = 1'b0;
                else if (new_step_reg == acc_reg[SW-1:0])
                    going_back_next = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    step_out_next  = nstep_ext[2:0];
                    cv_upd_next    = changed || continuous_reg;
                    fire_one_next  = (route == ROUTE_ONE);
                    fire_two_next  = (route == ROUTE_TWO);
                    step_pos_next  = new_step_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            acc_reg        <= '0;
            mod_reg        <= '0;
            start_reg      <= '0;
            lm1_reg        <= '0;
            len_reg        <= '0;
            off_reg        <= '0;
            new_step_reg   <= '0;
            step_pos_reg   <= '0;
            going_back_reg <= 1'b0;
            clk_e_reg      <= 1'b0;
            rst_e_reg      <= 1'b0;
            clk_con_reg    <= 1'b0;
            addr_con_reg   <= 1'b0;
            addr_reg       <= '0;
            lcv_reg        <= '0;
            mode_reg       <= '0;
            rnd_reg        <= '0;
            out_valid_reg  <= 1'b0;
            step_out_reg   <= '0;
            cv_upd_reg     <= 1'b0;
            fire_one_reg   <= 1'b0;
            fire_two_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            acc_reg        <= acc_next;
            mod_reg        <= mod_next;
            start_reg      <= start_next;
            lm1_reg        <= lm1_next;
            len_reg        <= len_next;
            off_reg        <= off_next;
            new_step_reg   <= new_step_next;
            step_pos_reg   <= step_pos_next;
            going_back_reg <= going_back_next;
            clk_e_reg      <= clk_e_next;
            rst_e_reg      <= rst_e_next;
            clk_con_reg    <= clk_con_next;
            addr_con_reg   <= addr_con_next;
            addr_reg       <= addr_next;
            lcv_reg        <= lcv_next;
            mode_reg       <= mode_next;
            rnd_reg        <= rnd_next;
            out_valid_reg  <= out_valid_next;
            step_out_reg   <= step_out_next;
            cv_upd_reg     <= cv_upd_next;
            fire_one_reg   <= fire_one_next;
            fire_two_reg   <= fire_two_next;
        end
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign current_step     = step_out_reg;
    assign cv_update        = cv_upd_reg;
    assign fire_trigger_one = fire_one_reg;
    assign fire_trigger_two = fire_two_reg;

`ifndef ASSERT_OFF
    // stored step stays on the ring
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        {{(AW-SW){1'b0}}, step_pos_reg} < ACC_STEPS)
        else $error("step position left the ring");

    // reduction never runs against a zero modulus
    a_mod_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RED) |-> (mod_reg != '0))
        else $error("reduction with zero modulus");

    // window length is in range when the offset is formed
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |->
            (len_reg != '0) && ({{(AW-LW){1'b0}}, len_reg} <= ACC_STEPS))
        else $error("window length out of range");

    // a new result word only comes from the finish step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("output word raised outside finish");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import wss_pkg::*;

    localparam int NSTEP          = NUM_STEPS_DEF;
    localparam int ITEMS_PER_SET  = 92;
    localparam int KNOB_SETS      = 6;
    localparam int QUIET_SET      = 3;
    localparam int IDLE_PCT       = 21;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;

    // One tick word as it appears on the input ports
    typedef struct packed {
        logic       clock_edge;
        logic       reset_edge;
        logic       clock_connected;
        logic       address_connected;
        logic [8:0] address_level;
        logic [3:0] start_cv;
        logic [3:0] length_cv;
        logic [1:0] mode_cv;
        logic [7:0] random_fraction;
    } tick_t;

    // One result word
    typedef struct packed {
        logic [2:0] step;
        logic       cv_update;
        logic       trig_one;
        logic       trig_two;
    } step_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    tick_t                 tick_bus = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            current_step;
    logic                  cv_update;
    logic                  fire_trigger_one;
    logic                  fire_trigger_two;

    // Knob copy and sequencer state kept by the predictor
    logic [2:0]  knob_start = START_KNOB_RST;
    logic [2:0]  knob_length = LENGTH_KNOB_RST;
    logic [1:0]  knob_mode = MODE_KNOB_RST;
    logic        knob_continuous = CONTINUOUS_RST;
    logic [15:0] knob_routing = ROUTING_RST;
    logic [2:0]  step_pos = '0;
    logic        heading_back = 1'b0;

    tick_t     tick_queue[$];
    step_out_t expected_steps[$];
    int        error_count = 0;
    int        idle_cycles = 0;
    bit        no_gaps = 1'b0;

    windowed_step_sequencer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .clock_edge        (tick_bus.clock_edge),
        .reset_edge        (tick_bus.reset_edge),
        .clock_connected   (tick_bus.clock_connected),
        .address_connected (tick_bus.address_connected),
        .address_level     (tick_bus.address_level),
        .start_cv          (tick_bus.start_cv),
        .length_cv         (tick_bus.length_cv),
        .mode_cv           (tick_bus.mode_cv),
        .random_fraction   (tick_bus.random_fraction),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .current_step      (current_step),
        .cv_update         (cv_update),
        .fire_trigger_one  (fire_trigger_one),
        .fire_trigger_two  (fire_trigger_two)
    );

    always #10 clk = ~clk;

    // Advance the predicted sequencer by one tick and return its result word
    function automatic step_out_t advance_sequencer(tick_t t);
        int unsigned win_start;
        int unsigned win_len;
        int unsigned addr;
        int unsigned rel;
        int unsigned nstep;
        logic [1:0]  mode;
        logic [1:0]  route;
        logic        fwd;
        logic        moved;
        step_out_t   r;
        win_start = knob_start;
        win_start = (win_start + t.start_cv) % NSTEP;
        win_len = knob_length;
        win_len = (win_len + t.length_cv) % NSTEP + 1;
        mode = knob_mode + t.mode_cv;
        nstep = step_pos;
        addr = t.address_level;
        if (addr > ADDR_FULL)
            addr = ADDR_FULL;
        if (mode != MODE_PENDULUM)
            heading_back = 1'b0;

        if (t.reset_edge)
            nstep = win_start;
        else if (t.address_connected)
        begin
            if (!t.clock_connected || t.clock_edge)
                nstep = (win_start + ((addr * win_len) >> 8)) % NSTEP;
        end
        else if (t.clock_edge)
        begin
            if (mode == MODE_RANDOM)
                nstep = (win_start + ((t.random_fraction * win_len) >> 8)) % NSTEP;
            else
            begin
                // walk relative to the window start; wraps inside the window
                rel = (nstep + NSTEP - win_start) % NSTEP;
                fwd = (mode == MODE_FORWARD) || (mode == MODE_PENDULUM && !heading_back);
                if (fwd)
                    rel = (rel + 1) % win_len;
                else
                    rel = (rel + win_len - 1) % win_len;
                nstep = (rel + win_start) % NSTEP;
                if (mode == MODE_PENDULUM)
                begin
                    if (nstep == win_start)
                        heading_back = 1'b0;
                    else if (nstep == (win_start + win_len - 1) % NSTEP)
                        heading_back = 1'b1;
                end
            end
        end

        moved = (t.clock_connected && t.clock_edge) || (nstep != step_pos);
        step_pos = nstep[2:0];
        route = moved ? 2'(knob_routing >> (2 * nstep)) : 2'd0;
        r.step = nstep[2:0];
        r.cv_update = moved || knob_continuous;
        r.trig_one = (route == ROUTE_ONE);
        r.trig_two = (route == ROUTE_TWO);
        return r;
    endfunction

    // Tick driver: holds the word until it is taken
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (tick_queue.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT))
            begin
                tick_bus <= tick_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side backpressure
    always @(posedge clk)
        out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);

    // Monitor: predict on accepted ticks, check accepted results
    always @(posedge clk)
    begin
        step_out_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_steps.push_back(advance_sequencer(tick_bus));
            if (out_valid && !out_stall)
            begin
                if (expected_steps.size() == 0)
                begin
                    $error("result word with none pending: current_step %0d", current_step);
                    error_count++;
                end
                else
                begin
                    want = expected_steps.pop_front();
                    if (current_step !== want.step)
                    begin
                        $error("current_step expected %0d got %0d", want.step, current_step);
                        error_count++;
                    end
                    if (cv_update !== want.cv_update)
                    begin
                        $error("cv_update expected %0b got %0b", want.cv_update, cv_update);
                        error_count++;
                    end
                    if (fire_trigger_one !== want.trig_one)
                    begin
                        $error("fire_trigger_one expected %0b got %0b",
                               want.trig_one, fire_trigger_one);
                        error_count++;
                    end
                    if (fire_trigger_two !== want.trig_two)
                    begin
                        $error("fire_trigger_two expected %0b got %0b",
                               want.trig_two, fire_trigger_two);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_tick(input logic ce, input logic re, input logic cc, input logic ac,
                            input logic [8:0] addr, input logic [3:0] scv,
                            input logic [3:0] lcv, input logic [1:0] mcv,
                            input logic [7:0] rnd);
        tick_queue.push_back(tick_t'{ce, re, cc, ac, addr, scv, lcv, mcv, rnd});
    endtask

    // Wait until every word has gone in and every result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || in_valid || expected_steps.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_START_KNOB:  knob_start = value[2:0];
            CFG_LENGTH_KNOB: knob_length = value[2:0];
            CFG_MODE_KNOB:   knob_mode = value[1:0];
            CFG_CONTINUOUS:  knob_continuous = value[0];
            CFG_ROUTING:     knob_routing = value;
            default: ;
        endcase
    endtask

    task automatic load_knobs(input logic [2:0] s, input logic [2:0] l, input logic [1:0] m,
                              input logic c, input logic [15:0] routing);
        write_reg(CFG_START_KNOB, 16'(s));
        write_reg(CFG_LENGTH_KNOB, 16'(l));
        write_reg(CFG_MODE_KNOB, 16'(m));
        write_reg(CFG_CONTINUOUS, 16'(c));
        write_reg(CFG_ROUTING, routing);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        tick_t      t;
        int         made;
        int         run_len;
        int         k;
        int         knob_set;
        bit         addr_run;
        logic [3:0] run_scv;
        logic [3:0] run_lcv;
        logic [1:0] run_mcv;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: default knobs, modes picked through mode_cv
        add_tick(0, 0, 1, 0, 9'd0,   4'd0,  4'd0, MODE_FORWARD,  8'd0);   // hold
        add_tick(1, 0, 1, 0, 9'd0,   4'd0,  4'd0, MODE_FORWARD,  8'd0);
        add_tick(1, 0, 1, 0, 9'd0,   4'd0,  4'd0, MODE_FORWARD,  8'd0);
        add_tick(1, 0, 1, 0, 9'd0,   4'd0,  4'd0, MODE_BACKWARD, 8'd0);
        add_tick(1, 0, 1, 0, 9'd0,   4'd0,  4'd2, MODE_PENDULUM, 8'd0);   // length 2
        add_tick(1, 0, 1, 0, 9'd0,   4'd0,  4'd2, MODE_PENDULUM, 8'd0);
        add_tick(1, 0, 1, 0, 9'd0,   4'd0,  4'd2, MODE_PENDULUM, 8'd0);
        add_tick(1, 0, 1, 0, 9'd0,   4'd0,  4'd1, MODE_PENDULUM, 8'd0);   // length 1
        add_tick(1, 0, 1, 0, 9'd0,   4'd0,  4'd0, MODE_RANDOM,   8'd0);
        add_tick(1, 0, 1, 0, 9'd0,   4'd0,  4'd0, MODE_RANDOM,   8'd255);
        add_tick(0, 1, 1, 0, 9'd0,   4'd15, 4'd15, MODE_FORWARD, 8'd0);   // reset to 7
        // step 7 now sits outside a window of 0..4
        add_tick(1, 0, 1, 0, 9'd0,   4'd0,  4'd5, MODE_FORWARD,  8'd0);
        add_tick(0, 1, 1, 0, 9'd0,   4'd7,  4'd0, MODE_FORWARD,  8'd0);
        add_tick(1, 0, 1, 0, 9'd0,   4'd0,  4'd5, MODE_BACKWARD, 8'd0);
        // address mode with clock unpatched: follows every tick
        add_tick(0, 0, 0, 1, 9'd0,   4'd0,  4'd0, MODE_FORWARD,  8'd0);
        add_tick(0, 0, 0, 1, 9'd256, 4'd0,  4'd0, MODE_FORWARD,  8'd0);
        add_tick(0, 0, 0, 1, 9'd511, 4'd3,  4'd8, MODE_FORWARD,  8'd0);
        add_tick(0, 0, 0, 1, 9'd128, 4'd8,  4'd0, MODE_FORWARD,  8'd0);
        // address mode with clock patched: only on an edge
        add_tick(0, 0, 1, 1, 9'd200, 4'd0,  4'd0, MODE_FORWARD,  8'd0);
        add_tick(1, 0, 1, 1, 9'd200, 4'd0,  4'd0, MODE_FORWARD,  8'd0);
        // edge on an unpatched clock; reset and clock together
        add_tick(1, 0, 0, 0, 9'd0,   4'd0,  4'd0, MODE_FORWARD,  8'd0);
        add_tick(1, 1, 1, 0, 9'd0,   4'd2,  4'd0, MODE_FORWARD,  8'd0);
        wait_drained();

        for (knob_set = 0; knob_set < KNOB_SETS; knob_set++)
        begin
            case (knob_set)
                0: load_knobs(3'd0, 3'd0, MODE_PENDULUM, 1'b1, 16'hFFFF);
                1: load_knobs(3'd7, 3'd7, MODE_RANDOM, 1'b0, 16'h0000);
                2: load_knobs(3'd7, 3'd0, MODE_BACKWARD, 1'b1, 16'h5555);
                default: load_knobs(3'($urandom), 3'($urandom), 2'($urandom),
                                    1'($urandom), 16'($urandom));
            endcase
            no_gaps = (knob_set == QUIET_SET);

            // runs of clocked ticks under fixed CVs, with noise mixed in
            made = 0;
            while (made < ITEMS_PER_SET)
            begin
                run_len = $urandom_range(4, 20);
                run_scv = 4'($urandom);
                run_lcv = 4'($urandom);
                run_mcv = 2'($urandom);
                addr_run = ($urandom_range(9) == 0);
                for (k = 0; k < run_len && made < ITEMS_PER_SET; k++)
                begin
                    if ($urandom_range(3) == 0)
                        t = tick_t'($urandom);
                    else
                    begin
                        t.clock_edge = ($urandom_range(9) < 7);
                        t.reset_edge = ($urandom_range(29) == 0);
                        t.clock_connected = 1'b1;
                        t.address_connected = addr_run;
                        t.address_level = 9'($urandom_range(256));
                        t.start_cv = run_scv;
                        t.length_cv = run_lcv;
                        t.mode_cv = run_mcv;
                        t.random_fraction = 8'($urandom);
                    end
                    tick_queue.push_back(t);
                    made++;
                end
            end
            wait_drained();
        end

        no_gaps = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
